@@ rtl/erx_pkg.sv @@
package erx_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'hBB;
    localparam logic [7:0] TAIL_BYTE = 8'hEE;
    localparam logic [2:0] FRAME_LEN = 3'd5;
    localparam logic [7:0] VALUE_MAX = 8'd100;

    localparam logic [15:0] WINDOW_TICKS_RESET = 16'd1000;
    localparam logic [15:0] LOSS_TICKS_RESET   = 16'd3000;

    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int REPORT_BITS          = 16;

    typedef enum logic [0:0] {
        REG_WINDOW_TICKS = 1'b0,
        REG_LOSS_TICKS   = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    // per-byte events from the frame assembler to the statistics unit
    typedef struct packed {
        logic       byte_seen;
        logic       discard;
        logic       error;
        logic       ok;
        logic [7:0] discard_byte;
    } frame_evt_t;

    typedef struct packed {
        logic       frame_ok;
        logic [6:0] attention;
        logic [6:0] fatigue;
        logic [6:0] quality;
        logic       frame_error;
    } frame_res_t;

    typedef struct packed {
        logic        stats_ready;
        logic [15:0] bytes_seen;
        logic [15:0] discards;
        logic [15:0] err_total;
        logic [7:0]  recent_drop;
        logic        signal_lost;
    } tick_res_t;

endpackage

@@ rtl/erx_frame_unit.sv @@
module erx_frame_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_en,
    input  logic [7:0]            rx_byte,
    output erx_pkg::frame_evt_t   evt,
    output erx_pkg::frame_res_t   res
);

    logic [2:0] frame_pos_reg;
    logic [2:0] frame_pos_next;
    logic [7:0] frame_bytes_reg [4];
    logic       store_en;
    logic       in_range;

    assign in_range = (frame_bytes_reg[1] <= erx_pkg::VALUE_MAX)
                   && (frame_bytes_reg[2] <= erx_pkg::VALUE_MAX)
                   && (frame_bytes_reg[3] <= erx_pkg::VALUE_MAX);

    always_comb begin
        frame_pos_next = frame_pos_reg;
        store_en       = 1'b0;
        evt            = '0;
        res            = '0;
        if (byte_en) begin
            evt.byte_seen = 1'b1;
            priority if (frame_pos_reg == 3'd0 && rx_byte != erx_pkg::HEAD_BYTE) begin
                evt.discard      = 1'b1;
                evt.discard_byte = rx_byte;
            end else if (frame_pos_reg < erx_pkg::FRAME_LEN - 3'd1) begin
                store_en       = 1'b1;
                frame_pos_next = frame_pos_reg + 3'd1;
            end else begin
                frame_pos_next = 3'd0;
                if (frame_bytes_reg[0] != erx_pkg::HEAD_BYTE
                        || rx_byte != erx_pkg::TAIL_BYTE) begin
                    evt.error       = 1'b1;
                    res.frame_error = 1'b1;
                end else if (in_range) begin
                    evt.ok        = 1'b1;
                    res.frame_ok  = 1'b1;
                    res.attention = frame_bytes_reg[1][6:0];
                    res.fatigue   = frame_bytes_reg[2][6:0];
                    res.quality   = 7'(erx_pkg::VALUE_MAX - frame_bytes_reg[3]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= 3'd0;
        end else begin
            frame_pos_reg <= frame_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            frame_bytes_reg[frame_pos_reg[1:0]] <= rx_byte;
        end
    end

endmodule

@@ rtl/erx_tick_unit.sv @@
module erx_tick_unit #(
    parameter int COUNTER_BITS = erx_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_en,
    input  erx_pkg::frame_evt_t  evt,
    input  logic [15:0]          window_ticks,
    input  logic [15:0]          loss_ticks,
    output erx_pkg::tick_res_t   res
);

    localparam int WIDE_BITS = (COUNTER_BITS > erx_pkg::REPORT_BITS)
                             ? COUNTER_BITS : erx_pkg::REPORT_BITS;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [COUNTER_BITS-1:0] byte_cnt_reg, byte_cnt_next;
    logic [COUNTER_BITS-1:0] discard_cnt_reg, discard_cnt_next;
    logic [COUNTER_BITS-1:0] error_cnt_reg, error_cnt_next;
    logic [7:0]              drop_byte_reg, drop_byte_next;
    logic [15:0]             window_timer_reg, window_timer_next;
    logic [15:0]             loss_timer_reg, loss_timer_next;
    logic                    loss_armed_reg, loss_armed_next;
    logic                    window_close;

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] report(input logic [COUNTER_BITS-1:0] v);
        logic [WIDE_BITS-1:0] wide;
        wide   = WIDE_BITS'(v);
        report = (wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
    endfunction

    assign window_close = ({1'b0, window_timer_reg} + 17'd1) >= {1'b0, window_ticks};

    always_comb begin
        byte_cnt_next     = byte_cnt_reg;
        discard_cnt_next  = discard_cnt_reg;
        error_cnt_next    = error_cnt_reg;
        drop_byte_next    = drop_byte_reg;
        window_timer_next = window_timer_reg;
        loss_timer_next   = loss_timer_reg;
        loss_armed_next   = loss_armed_reg;
        res               = '0;

        if (evt.byte_seen) begin
            byte_cnt_next = sat_inc(byte_cnt_reg);
        end
        if (evt.discard) begin
            discard_cnt_next = sat_inc(discard_cnt_reg);
            drop_byte_next   = evt.discard_byte;
        end
        if (evt.error) begin
            error_cnt_next = sat_inc(error_cnt_reg);
        end
        if (evt.ok) begin
            loss_armed_next = 1'b1;
            loss_timer_next = 16'd0;
        end

        if (tick_en) begin
            if (window_close) begin
                res.stats_ready   = 1'b1;
                res.bytes_seen    = report(byte_cnt_reg);
                res.discards      = report(discard_cnt_reg);
                res.err_total     = report(error_cnt_reg);
                res.recent_drop   = drop_byte_reg;
                byte_cnt_next     = '0;
                discard_cnt_next  = '0;
                error_cnt_next    = '0;
                drop_byte_next    = 8'd0;
                window_timer_next = 16'd0;
            end else begin
                window_timer_next = window_timer_reg + 16'd1;
            end
            if (loss_armed_reg) begin
                if (loss_timer_reg >= loss_ticks) begin
                    res.signal_lost = 1'b1;
                    loss_armed_next = 1'b0;
                    loss_timer_next = 16'd0;
                end else begin
                    loss_timer_next = loss_timer_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg     <= '0;
            discard_cnt_reg  <= '0;
            error_cnt_reg    <= '0;
            drop_byte_reg    <= 8'd0;
            window_timer_reg <= 16'd0;
            loss_timer_reg   <= 16'd0;
            loss_armed_reg   <= 1'b0;
        end else begin
            byte_cnt_reg     <= byte_cnt_next;
            discard_cnt_reg  <= discard_cnt_next;
            error_cnt_reg    <= error_cnt_next;
            drop_byte_reg    <= drop_byte_next;
            window_timer_reg <= window_timer_next;
            loss_timer_reg   <= loss_timer_next;
            loss_armed_reg   <= loss_armed_next;
        end
    end

endmodule

@@ rtl/eeg_frame_receiver_core.sv @@
// Framed serial receiver with window statistics and a signal-loss watchdog.
// Input stream (s_*): one item per received byte (s_tuser = 0, byte in
// s_tdata) or per millisecond tick (s_tuser = 1, s_tdata ignored).
// Result stream (m_*): exactly one item per input item, in order. m_tuser
// flags a valid frame, a frame error, a closed window and signal loss;
// m_tdata carries the frame values and the window counters, zero where a
// flag does not apply.
// Configuration: cfg_we writes window_ticks (index 0) or loss_ticks
// (index 1) from cfg_wdata; write only while no item is in flight.
// Data path: an accepted item passes the input register, then the frame
// and statistics logic into the result register that drives m_tvalid.
// Throughput: one item per cycle while m_tready is high; the frame
// position and counters update as each item leaves the input register.
// When m_tready is low the result register holds and one more item is
// taken into the input register before s_tready drops.
// Reset (aresetn low, synchronous) empties both registers, closes any open
// frame, clears counters and timers, disarms the watchdog and restores the
// register defaults of 1000 and 3000 ticks.
module eeg_frame_receiver_core #(
    parameter int COUNTER_BITS = erx_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // attention, fatigue, quality, bytes_seen, discards, err_total,
    // recent_drop, zero pad
    output logic [79:0] m_tdata,
    // frame_ok, frame_error, stats_ready, signal_lost
    output logic [3:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic        in_valid_reg;
    logic        in_type_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic [3:0]  out_user_reg;
    logic [15:0] window_ticks_reg;
    logic [15:0] loss_ticks_reg;
    logic        advance;
    logic        byte_en;
    logic        tick_en;

    erx_pkg::frame_evt_t frame_evt;
    erx_pkg::frame_res_t frame_res;
    erx_pkg::tick_res_t  tick_res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign byte_en  = advance && (in_type_reg == erx_pkg::REQ_BYTE);
    assign tick_en  = advance && (in_type_reg == erx_pkg::REQ_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ticks_reg <= erx_pkg::WINDOW_TICKS_RESET;
            loss_ticks_reg   <= erx_pkg::LOSS_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (erx_pkg::cfg_reg_t'(cfg_addr))
                erx_pkg::REG_WINDOW_TICKS: window_ticks_reg <= cfg_wdata;
                erx_pkg::REG_LOSS_TICKS:   loss_ticks_reg   <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    erx_frame_unit u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (in_byte_reg),
        .evt     (frame_evt),
        .res     (frame_res)
    );

    erx_tick_unit #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_tick (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .evt          (frame_evt),
        .window_ticks (window_ticks_reg),
        .loss_ticks   (loss_ticks_reg),
        .res          (tick_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000,
                             tick_res.recent_drop,
                             tick_res.err_total,
                             tick_res.discards,
                             tick_res.bytes_seen,
                             frame_res.quality,
                             frame_res.fatigue,
                             frame_res.attention};
            out_user_reg <= {tick_res.signal_lost,
                             tick_res.stats_ready,
                             frame_res.frame_error,
                             frame_res.frame_ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_no_byte_and_tick_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((m_tuser[0] || m_tuser[1]) && (m_tuser[2] || m_tuser[3])))
        else $error("byte and tick flags on one item");

    a_ok_excludes_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("frame_ok and frame_error together");

    a_held_input_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                         && $stable(in_type_reg)))
        else $error("stalled input item lost");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("pipeline not empty after reset");

endmodule
